/* rtl/lpfd_pkg.sv */
// Package for the polynomial-counter fetch and decode unit.
// Holds the request and result types, state type, mnemonic codes and decode functions.
// No dependencies.
`default_nettype none

package lpfd_pkg;

    // Opcode bounds of the long transfer group, and the fixed offset of the counter
    localparam logic [7:0] LONG_FIRST = 8'h78;
    localparam logic [7:0] SHORT_FIRST = 8'h80;
    localparam logic [7:0] TML_FIRST = 8'h7c;
    localparam logic [6:0] OFFSET_FIXED = 7'd127;

    typedef enum logic [5:0] {
        MN_NOP    = 6'd0,
        MN_ADI    = 6'd1,
        MN_SKAI   = 6'd2,
        MN_LBLI   = 6'd3,
        MN_LDI    = 6'd4,
        MN_L      = 6'd5,
        MN_X      = 6'd6,
        MN_XI     = 6'd7,
        MN_XD     = 6'd8,
        MN_NEGA   = 6'd9,
        MN_OUT    = 6'd10,
        MN_OUT0   = 6'd11,
        MN_SC     = 6'd12,
        MN_RC     = 6'd13,
        MN_S      = 6'd14,
        MN_RIT    = 6'd15,
        MN_RITSK  = 6'd16,
        MN_LI     = 6'd17,
        MN_COMA   = 6'd18,
        MN_IN     = 6'd19,
        MN_XAL    = 6'd20,
        MN_LXA    = 6'd21,
        MN_XAX    = 6'd22,
        MN_SKM    = 6'd23,
        MN_SKA    = 6'd24,
        MN_RM     = 6'd25,
        MN_SM     = 6'd26,
        MN_AD     = 6'd27,
        MN_ADC    = 6'd28,
        MN_ADCSK  = 6'd29,
        MN_LBMI   = 6'd30,
        MN_TL     = 6'd31,
        MN_TML    = 6'd32,
        MN_T      = 6'd33,
        MN_UNKNOWN = 6'd34
    } t_mnemonic;

    typedef struct packed {
        logic       func;
        logic [1:0] start_segment;
        logic [6:0] start_offset;
        logic [7:0] code_byte;
    } t_request;

    typedef struct packed {
        logic       insn_done;
        logic [8:0] insn_address;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] insn_length;
        t_mnemonic  mnemonic;
        logic [3:0] immediate;
        logic [9:0] target_address;
        logic [8:0] next_fetch_address;
    } t_result;

    typedef struct packed {
        logic [1:0] segment;
        logic [6:0] offset;
        logic       long_pending;
        logic [7:0] held_opcode;
        logic [8:0] held_address;
    } t_fetch_state;

    // One step of the polynomial counter; offset 127 maps to itself
    function automatic logic [6:0] step_offset(input logic [6:0] off);
        logic fb;
        fb = off[0] ^ off[1];
        return {~fb, off[6:1]};
    endfunction

    // Long transfer first byte: 0x78..0x7f
    function automatic logic is_long(input logic [7:0] op);
        return (op[7:3] == LONG_FIRST[7:3]);
    endfunction

    // Mnemonic of a one-byte opcode
    function automatic t_mnemonic single_mnemonic(input logic [7:0] op);
        t_mnemonic mn;
        mn = MN_UNKNOWN;
        if (op == 8'h00) begin
            mn = MN_NOP;
        end else if (op[7]) begin
            mn = MN_T;
        end else begin
            case (op[6:4])
                3'h0: mn = MN_ADI;
                3'h1: mn = MN_SKAI;
                3'h2: mn = MN_LBLI;
                3'h3: mn = MN_LDI;
                3'h6, 3'h7: begin
                    case (op[4:2])
                        3'b000: mn = MN_SKM;
                        3'b001: mn = MN_SKA;
                        3'b010: mn = MN_RM;
                        3'b011: mn = MN_SM;
                        3'b101: mn = MN_LBMI;
                        3'b100: begin
                            case (op[1:0])
                                2'd0: mn = MN_AD;
                                2'd2: mn = MN_ADC;
                                2'd3: mn = MN_ADCSK;
                                default: mn = MN_UNKNOWN;
                            endcase
                        end
                        default: mn = MN_UNKNOWN;
                    endcase
                end
                default: begin
                    case (op[4:0])
                        5'h00: mn = MN_L;
                        5'h01: mn = MN_X;
                        5'h02: mn = MN_XI;
                        5'h03: mn = MN_XD;
                        5'h04: mn = MN_NEGA;
                        5'h06: mn = MN_OUT;
                        5'h07: mn = MN_OUT0;
                        5'h08: mn = MN_SC;
                        5'h09: mn = MN_RC;
                        5'h0a: mn = MN_S;
                        5'h0c: mn = MN_RIT;
                        5'h0d: mn = MN_RITSK;
                        5'h12: mn = MN_LI;
                        5'h14: mn = MN_COMA;
                        5'h15: mn = MN_IN;
                        5'h17: mn = MN_XAL;
                        5'h1c: mn = MN_LXA;
                        5'h1d: mn = MN_XAX;
                        default: mn = MN_UNKNOWN;
                    endcase
                end
            endcase
        end
        return mn;
    endfunction

    // Immediate of a one-byte opcode
    function automatic logic [3:0] single_immediate(input logic [7:0] op);
        logic [3:0] imm;
        imm = 4'd0;
        if (op != 8'h00 && op[7:6] == 2'b00) begin
            imm = op[3:0];
        end else if (op[7:5] == 3'b011 && !(op[4] && op[3])) begin
            imm = {2'b00, op[1:0]};
        end
        return imm;
    endfunction

endpackage

`default_nettype wire

/* rtl/lfsr_pc_fetch_decode.sv */
// Top level of the polynomial-counter fetch and decode unit.
// Input register, decode, fetch state and result register. Depends on lpfd_pkg, lpfd_decode.
//
//  channel | direction | handshake                       | payload
//  request | in        | i_in_valid / o_in_stall         | i_in_data  (t_request)
//  result  | out       | o_out_valid / i_out_stall       | o_out_data (t_result)
//
// One request per cycle sustained while i_out_stall stays low; a request passes from the
// input register, which feeds the decode logic, to the result register behind it.
// Synchronous active-low reset clears the fetch state (address 0, nothing held) and valids.
// A stalled result register holds its result; the input register keeps accepting while
// it is empty, so one request is taken while a finished result waits.
`default_nettype none

module lfsr_pc_fetch_decode (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire lpfd_pkg::t_request i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output lpfd_pkg::t_result     o_out_data,
    input  wire                   i_out_stall
);

    logic                   r_in_valid;
    lpfd_pkg::t_request     r_in;
    lpfd_pkg::t_fetch_state r_state;
    logic                   r_out_valid;
    lpfd_pkg::t_result      r_out;

    lpfd_pkg::t_result      n_out;
    lpfd_pkg::t_fetch_state n_state;
    logic                   advance;

    // Stage 1 moves into the result register when that is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    lpfd_decode u_decode (
        .i_req   (r_in),
        .i_state (r_state),
        .o_res   (n_out),
        .o_state (n_state)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Fetch state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A held byte is always a long transfer opcode
    a_held_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.long_pending |-> lpfd_pkg::is_long(r_state.held_opcode))
        else $error("held opcode is not a long transfer");

    // Two-byte results come only from long transfer opcodes
    a_len_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.insn_length == 2'd2) |->
        (o_out_data.insn_done && lpfd_pkg::is_long(o_out_data.first_byte)))
        else $error("two-byte result with wrong opcode");

    // Empty input register never stalls
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall with empty input register");

    // Fetch state changes only when a request moves to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("fetch state changed without a request");
`endif

endmodule

`default_nettype wire

/* rtl/lpfd_decode.sv */
// Combinational decode of one code byte against the fetch state.
// Produces the result and the next fetch state. Depends on lpfd_pkg.
`default_nettype none

module lpfd_decode (
    input  wire lpfd_pkg::t_request     i_req,
    input  wire lpfd_pkg::t_fetch_state i_state,
    output lpfd_pkg::t_result           o_res,
    output lpfd_pkg::t_fetch_state      o_state
);

    logic [1:0] seg;
    logic [6:0] off;
    logic [6:0] off_step;
    logic       pend;
    logic [7:0] op;
    logic       long_op;

    // Restart overrides fetch address and drops a held byte
    always_comb begin
        seg      = i_req.func ? i_req.start_segment : i_state.segment;
        off      = i_req.func ? i_req.start_offset : i_state.offset;
        pend     = i_req.func ? 1'b0 : i_state.long_pending;
        op       = i_req.code_byte;
        off_step = lpfd_pkg::step_offset(off);
        long_op  = lpfd_pkg::is_long(op);
    end

    // Result selection
    always_comb begin
        o_res = '0;
        o_res.mnemonic = lpfd_pkg::MN_NOP;
        o_res.next_fetch_address = {seg, off_step};
        if (pend) begin
            // second byte of a long transfer
            o_res.insn_done      = 1'b1;
            o_res.insn_address   = i_state.held_address;
            o_res.first_byte     = i_state.held_opcode;
            o_res.second_byte    = op;
            o_res.insn_length    = 2'd2;
            o_res.mnemonic       = (i_state.held_opcode < lpfd_pkg::TML_FIRST) ?
                                   lpfd_pkg::MN_TL : lpfd_pkg::MN_TML;
            o_res.target_address = {i_state.held_opcode[1:0], op};
        end else if (!long_op) begin
            o_res.insn_done    = 1'b1;
            o_res.insn_address = {seg, off};
            o_res.first_byte   = op;
            o_res.insn_length  = 2'd1;
            o_res.mnemonic     = lpfd_pkg::single_mnemonic(op);
            o_res.immediate    = lpfd_pkg::single_immediate(op);
            if (op >= lpfd_pkg::SHORT_FIRST) begin
                o_res.target_address = {1'b0, seg, op[6:0]};
            end
        end
    end

    // Next fetch state
    always_comb begin
        o_state.segment      = seg;
        o_state.offset       = off_step;
        o_state.long_pending = !pend && long_op;
        o_state.held_opcode  = i_state.held_opcode;
        o_state.held_address = i_state.held_address;
        if (!pend && long_op) begin
            o_state.held_opcode  = op;
            o_state.held_address = {seg, off};
        end
    end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Testbench for lfsr_pc_fetch_decode: directed and random code bytes, checked field by field
// against an in-bench predictor of the polynomial fetch counter and the opcode decoder.
// Depends on lpfd_pkg and the lfsr_pc_fetch_decode RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 200;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    lpfd_pkg::t_request i_in_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    lpfd_pkg::t_result  o_out_data;
    logic               i_out_stall = 1'b0;

    // Requests still to be sent, and results the block owes us
    lpfd_pkg::t_request pending_reqs[$];
    lpfd_pkg::t_result  expected_results[$];

    // Predicted fetch state
    logic [1:0] pc_seg;
    logic [6:0] pc_off;
    logic       long_held;
    logic [7:0] held_op;
    logic [8:0] held_addr;

    int n_total = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_long = 0;
    int n_restart = 0;
    int n_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic req_fired = 1'b0;

    wire quiet = (n_accepted + QUIET_TAIL >= n_total);

    lfsr_pc_fetch_decode uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Polynomial counter step: shift right, feedback into bit 6; 127 stays put
    function automatic logic [6:0] next_offset(input logic [6:0] off);
        logic fb;
        fb = off[1] ^ off[0];
        return (off >> 1) ^ {fb, 6'b0} ^ 7'h40;
    endfunction

    // Mnemonic of a single-byte opcode
    function automatic lpfd_pkg::t_mnemonic opcode_mnemonic(input logic [7:0] b);
        if (b == 8'h00) return lpfd_pkg::MN_NOP;
        if (b < 8'h10) return lpfd_pkg::MN_ADI;
        if (b < 8'h20) return lpfd_pkg::MN_SKAI;
        if (b < 8'h30) return lpfd_pkg::MN_LBLI;
        if (b < 8'h40) return lpfd_pkg::MN_LDI;
        if (b >= 8'h80) return lpfd_pkg::MN_T;
        if (b >= 8'h60 && b < 8'h64) return lpfd_pkg::MN_SKM;
        if (b >= 8'h64 && b < 8'h68) return lpfd_pkg::MN_SKA;
        if (b >= 8'h68 && b < 8'h6c) return lpfd_pkg::MN_RM;
        if (b >= 8'h6c && b < 8'h70) return lpfd_pkg::MN_SM;
        if (b >= 8'h74 && b < 8'h78) return lpfd_pkg::MN_LBMI;
        case (b)
            8'h40: return lpfd_pkg::MN_L;
            8'h41: return lpfd_pkg::MN_X;
            8'h42: return lpfd_pkg::MN_XI;
            8'h43: return lpfd_pkg::MN_XD;
            8'h44: return lpfd_pkg::MN_NEGA;
            8'h46: return lpfd_pkg::MN_OUT;
            8'h47: return lpfd_pkg::MN_OUT0;
            8'h48: return lpfd_pkg::MN_SC;
            8'h49: return lpfd_pkg::MN_RC;
            8'h4a: return lpfd_pkg::MN_S;
            8'h4c: return lpfd_pkg::MN_RIT;
            8'h4d: return lpfd_pkg::MN_RITSK;
            8'h52: return lpfd_pkg::MN_LI;
            8'h54: return lpfd_pkg::MN_COMA;
            8'h55: return lpfd_pkg::MN_IN;
            8'h57: return lpfd_pkg::MN_XAL;
            8'h5c: return lpfd_pkg::MN_LXA;
            8'h5d: return lpfd_pkg::MN_XAX;
            8'h70: return lpfd_pkg::MN_AD;
            8'h72: return lpfd_pkg::MN_ADC;
            8'h73: return lpfd_pkg::MN_ADCSK;
            default: return lpfd_pkg::MN_UNKNOWN;
        endcase
    endfunction

    // Advance the predicted fetch state by one request and return the expected result
    function automatic lpfd_pkg::t_result decode_fetch(input lpfd_pkg::t_request rq);
        lpfd_pkg::t_result res;
        logic [8:0]        here;
        logic [7:0]        b;
        res = '0;
        b = rq.code_byte;
        if (rq.func) begin
            pc_seg = rq.start_segment;
            pc_off = rq.start_offset;
            long_held = 1'b0;
            n_restart++;
        end
        here = {pc_seg, pc_off};
        pc_off = next_offset(pc_off);
        res.next_fetch_address = {pc_seg, pc_off};
        if (long_held) begin
            // second byte completes the long transfer
            long_held = 1'b0;
            n_long++;
            res.insn_done = 1'b1;
            res.insn_address = held_addr;
            res.first_byte = held_op;
            res.second_byte = b;
            res.insn_length = 2'd2;
            res.mnemonic = (held_op < lpfd_pkg::TML_FIRST) ? lpfd_pkg::MN_TL
                                                           : lpfd_pkg::MN_TML;
            res.target_address = {held_op[1:0], b};
        end else if (b >= lpfd_pkg::LONG_FIRST && b < lpfd_pkg::SHORT_FIRST) begin
            // first byte of a long transfer is held, nothing else reported
            long_held = 1'b1;
            held_op = b;
            held_addr = here;
        end else begin
            res.insn_done = 1'b1;
            res.insn_address = here;
            res.first_byte = b;
            res.insn_length = 2'd1;
            res.mnemonic = opcode_mnemonic(b);
            if (b >= 8'h01 && b <= 8'h3f)
                res.immediate = b[3:0];
            else if (b >= 8'h60 && b <= 8'h77)
                res.immediate = {2'b00, b[1:0]};
            if (b >= lpfd_pkg::SHORT_FIRST)
                res.target_address = {1'b0, pc_seg, b[6:0]};
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic add_req(input logic fn, input logic [1:0] seg, input logic [6:0] off,
                           input logic [7:0] b);
        lpfd_pkg::t_request rq;
        rq.func = fn;
        rq.start_segment = seg;
        rq.start_offset = off;
        rq.code_byte = b;
        pending_reqs.push_back(rq);
    endtask

    // Request driver: a new request only after the previous one was taken
    always @(negedge i_clk) begin
        logic               nxt_valid;
        lpfd_pkg::t_request nxt_data;
        nxt_valid = i_in_valid;
        nxt_data = i_in_data;
        if (i_rst_n && (!i_in_valid || req_fired)) begin
            if (gap_left > 0) begin
                nxt_valid = 1'b0;
                gap_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                nxt_valid = 1'b0;
                gap_left = $urandom_range(0, 4);
            end else if (pending_reqs.size() > 0) begin
                nxt_data = pending_reqs.pop_front();
                nxt_valid = 1'b1;
            end else begin
                nxt_valid = 1'b0;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt_data;
    end

    // Result receiver: short stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                nxt_stall = 1'b1;
                hold_left--;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                nxt_stall = 1'b1;
            end else if (stall_left > 0) begin
                nxt_stall = 1'b1;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                nxt_stall = 1'b1;
            end
        end
        i_out_stall <= nxt_stall;
    end

    // Monitor: predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        lpfd_pkg::t_result want;
        if (i_rst_n) begin
            req_fired <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    check_field("insn_done", want.insn_done, o_out_data.insn_done);
                    check_field("insn_address", want.insn_address, o_out_data.insn_address);
                    check_field("first_byte", want.first_byte, o_out_data.first_byte);
                    check_field("second_byte", want.second_byte, o_out_data.second_byte);
                    check_field("insn_length", want.insn_length, o_out_data.insn_length);
                    check_field("mnemonic", want.mnemonic, o_out_data.mnemonic);
                    check_field("immediate", want.immediate, o_out_data.immediate);
                    check_field("target_address", want.target_address,
                                o_out_data.target_address);
                    check_field("next_fetch_address", want.next_fetch_address,
                                o_out_data.next_fetch_address);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(decode_fetch(i_in_data));
                n_accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] b;
        int         r;
        pc_seg = '0;
        pc_off = '0;
        long_held = 1'b0;
        held_op = '0;
        held_addr = '0;

        // Directed: opcode group edges, long transfers, short transfer, fixed offset,
        // restart while a long first byte is held, unlisted opcodes
        add_req(1'b1, 2'd0, 7'd0, 8'h00);
        add_req(1'b0, 2'd3, 7'd127, 8'h0f);
        add_req(1'b0, 2'd0, 7'd0, 8'h10);
        add_req(1'b0, 2'd0, 7'd0, 8'h3f);
        add_req(1'b0, 2'd0, 7'd0, 8'h45);
        add_req(1'b0, 2'd0, 7'd0, 8'h60);
        add_req(1'b0, 2'd0, 7'd0, 8'h77);
        add_req(1'b0, 2'd0, 7'd0, 8'h78);
        add_req(1'b0, 2'd0, 7'd0, 8'hff);
        add_req(1'b0, 2'd0, 7'd0, 8'h7f);
        add_req(1'b0, 2'd0, 7'd0, 8'h00);
        add_req(1'b0, 2'd0, 7'd0, 8'h80);
        add_req(1'b0, 2'd0, 7'd0, 8'hff);
        add_req(1'b1, 2'd3, 7'd127, 8'h52);
        add_req(1'b0, 2'd0, 7'd0, 8'h71);
        add_req(1'b0, 2'd0, 7'd0, 8'h7c);
        add_req(1'b1, 2'd2, 7'h55, 8'h7b);
        add_req(1'b0, 2'd0, 7'd0, 8'h80);
        add_req(1'b1, 2'd1, 7'h2a, 8'h4f);
        add_req(1'b0, 2'd1, 7'h2a, 8'h40);
        add_req(1'b0, 2'd0, 7'd0, 8'h7e);
        add_req(1'b0, 2'd0, 7'd0, 8'h7f);

        // Random: mostly plain fetches, biased toward long transfers, some restarts
        for (int i = 0; i < 1600; i++) begin
            r = int'($urandom_range(0, 99));
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 6) == 0)
                b = lpfd_pkg::LONG_FIRST + 8'($urandom_range(0, 7));
            if (r < 6)
                add_req(1'b1, 2'($urandom_range(0, 3)),
                        ($urandom_range(0, 3) == 0) ? lpfd_pkg::OFFSET_FIXED
                                                    : 7'($urandom_range(0, 127)),
                        b);
            else
                add_req(1'b0, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), b);
        end
        n_total = pending_reqs.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d code bytes (%0d restarts), checked %0d results,",
                 n_accepted, n_restart, n_checked);
        $display("including %0d completed long transfers and one long receiver hold-off.",
                 n_long);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
